// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lpts_pkg.sv
// Types, codes and constant tables for the LED pattern and tone sequencer.
package lpts_pkg;

  // Build-time constants
  localparam int BREATHE_PERIOD_MS = 2000;
  localparam int MAX_TONES         = 3;
  localparam int BRW               = $clog2(BREATHE_PERIOD_MS);
  localparam int SEQ_COLS          = 3;

  // Blink timing
  localparam int FAST_MS        = 100;
  localparam int SLOW_MS        = 500;
  localparam int STUTTER_MS     = 50;
  localparam int SPARSE_MS      = 2000;
  localparam int STUTTER_PHASES = 6;
  localparam int STUTTER_ON     = 3;

  // Item kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_EVENT   = 3'd1;
  localparam logic [2:0] KIND_LINK    = 3'd2;
  localparam logic [2:0] KIND_EMERG   = 3'd3;
  localparam logic [2:0] KIND_ALIGN   = 3'd4;
  localparam logic [2:0] KIND_SILENCE = 3'd5;

  // Event codes
  localparam logic [3:0] EVT_BOOT      = 4'd1;
  localparam logic [3:0] EVT_READY     = 4'd2;
  localparam logic [3:0] EVT_TX        = 4'd3;
  localparam logic [3:0] EVT_RX        = 4'd4;
  localparam logic [3:0] EVT_SWITCH    = 4'd5;
  localparam logic [3:0] EVT_LORA_EMG  = 4'd6;
  localparam logic [3:0] EVT_ALIGN     = 4'd7;
  localparam logic [3:0] EVT_EMG_RX    = 4'd8;
  localparam logic [3:0] EVT_BATT_LOW  = 4'd9;
  localparam logic [3:0] EVT_BATT_CRIT = 4'd10;
  localparam logic [3:0] EVT_CRC_ERR   = 4'd11;

  // Link codes
  localparam logic [1:0] LINK_WIFI = 2'd1;
  localparam logic [1:0] LINK_FSO  = 2'd2;
  localparam logic [1:0] LINK_LORA = 2'd3;

  // Pattern codes
  localparam logic [2:0] PAT_OFF     = 3'd0;
  localparam logic [2:0] PAT_ON      = 3'd1;
  localparam logic [2:0] PAT_BREATHE = 3'd2;
  localparam logic [2:0] PAT_FAST    = 3'd3;
  localparam logic [2:0] PAT_SLOW    = 3'd4;
  localparam logic [2:0] PAT_DOUBLE  = 3'd5;
  localparam logic [2:0] PAT_SPARSE  = 3'd6;
  localparam logic [2:0] PAT_STUTTER = 3'd7;

  // Sequence codes
  localparam logic [2:0] SEQ_NONE   = 3'd0;
  localparam logic [2:0] SEQ_BOOT   = 3'd1;
  localparam logic [2:0] SEQ_SWITCH = 3'd2;
  localparam logic [2:0] SEQ_EMERG  = 3'd3;
  localparam logic [2:0] SEQ_BATT   = 3'd4;

  // Config register indexes
  localparam logic [1:0] REG_REFRESH = 2'd0;
  localparam logic [1:0] REG_ALIGN   = 2'd1;
  localparam logic [1:0] REG_GAP     = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  event_code;
    logic [1:0]  link_code;
    logic        emergency_on;
    logic [15:0] tone_freq;
  } item_t;

  typedef struct packed {
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [7:0]  red_level;
    logic        buzzer_on;
    logic [15:0] buzzer_freq;
  } result_t;

  typedef struct packed {
    logic [7:0] refresh_interval_ms;
    logic [9:0] alignment_tone_ms;
    logic [9:0] tone_gap_ms;
  } cfg_t;

  // Millisecond phase counters derived from time_ms
  typedef struct packed {
    logic [6:0]     c100;   // t mod 100
    logic [1:0]     q100;   // (t / 100) mod 4
    logic [8:0]     c500;   // t mod 500
    logic           h500;   // (t / 500) & 1
    logic [5:0]     c50;    // t mod 50
    logic [2:0]     q50;    // (t / 50) mod 6
    logic [10:0]    c2000;  // t mod 2000
    logic           h2000;  // (t / 2000) & 1
    logic [BRW-1:0] bm;     // t mod breathe period
    logic [BRW-1:0] br;     // (bm * 256) mod period
    logic [7:0]     bp;     // (bm * 256) / period
  } phase_t;

  // round(255*sin(pi*i/128)), quarter wave
  localparam logic [7:0] SINE_ROM [0:64] = '{
    8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
    8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
    8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
    8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
    8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
    8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
    8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255,
    8'd255
  };

  function automatic logic [15:0] seq_freq(logic [2:0] s, logic [1:0] i);
    logic [15:0] f;
    f = '0;
    case (s)
      SEQ_BOOT: begin
        case (i)
          2'd0:    f = 16'd523;
          2'd1:    f = 16'd659;
          2'd2:    f = 16'd784;
          default: f = '0;
        endcase
      end
      SEQ_SWITCH: begin
        case (i)
          2'd0:    f = 16'd600;
          2'd1:    f = 16'd500;
          2'd2:    f = 16'd400;
          default: f = '0;
        endcase
      end
      SEQ_EMERG: begin
        case (i)
          2'd0, 2'd1: f = 16'd1047;
          default:    f = '0;
        endcase
      end
      SEQ_BATT: begin
        case (i)
          2'd0, 2'd1: f = 16'd200;
          default:    f = '0;
        endcase
      end
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [15:0] seq_dur(logic [2:0] s, logic [1:0] i);
    logic [15:0] d;
    d = '0;
    case (s)
      SEQ_BOOT: begin
        case (i)
          2'd0, 2'd1: d = 16'd150;
          2'd2:       d = 16'd300;
          default:    d = '0;
        endcase
      end
      SEQ_SWITCH: begin
        case (i)
          2'd0, 2'd1: d = 16'd100;
          2'd2:       d = 16'd200;
          default:    d = '0;
        endcase
      end
      SEQ_EMERG: begin
        case (i)
          2'd0, 2'd1: d = 16'd100;
          default:    d = '0;
        endcase
      end
      SEQ_BATT: begin
        case (i)
          2'd0:    d = 16'd200;
          2'd1:    d = 16'd400;
          default: d = '0;
        endcase
      end
      default: d = '0;
    endcase
    return d;
  endfunction

  // Tones played by a sequence, capped at MAX_TONES
  function automatic logic [3:0] seq_count(logic [2:0] s);
    logic [3:0] n;
    case (s)
      SEQ_BOOT, SEQ_SWITCH: n = 4'd3;
      SEQ_EMERG, SEQ_BATT:  n = 4'd2;
      default:              n = 4'd0;
    endcase
    return (n > 4'(MAX_TONES)) ? 4'(MAX_TONES) : n;
  endfunction

endpackage

// File: rtl/lpts_timebase.sv
// Millisecond clock and the blink/breathe phase counters that follow it.
module lpts_timebase (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tick_en,
  output lpts_pkg::phase_t ph_nxt
);

  localparam int P = lpts_pkg::BREATHE_PERIOD_MS;
  localparam int W = lpts_pkg::BRW;

  logic [31:0]      time_r;
  logic [31:0]      time_nxt;
  lpts_pkg::phase_t ph_r;
  logic [W:0]       bsum;

  always_comb begin
    time_nxt = time_r + 32'd1;
    ph_nxt   = ph_r;
    bsum     = {1'b0, ph_r.br} + (W+1)'(256);
    if (time_r == '1) begin
      // 32-bit wrap: every phase restarts at zero
      ph_nxt = '0;
    end else begin
      if (ph_r.c100 == 7'(lpts_pkg::FAST_MS - 1)) begin
        ph_nxt.c100 = '0;
        ph_nxt.q100 = ph_r.q100 + 2'd1;
      end else begin
        ph_nxt.c100 = ph_r.c100 + 7'd1;
      end
      if (ph_r.c500 == 9'(lpts_pkg::SLOW_MS - 1)) begin
        ph_nxt.c500 = '0;
        ph_nxt.h500 = ~ph_r.h500;
      end else begin
        ph_nxt.c500 = ph_r.c500 + 9'd1;
      end
      if (ph_r.c50 == 6'(lpts_pkg::STUTTER_MS - 1)) begin
        ph_nxt.c50 = '0;
        ph_nxt.q50 = (ph_r.q50 == 3'(lpts_pkg::STUTTER_PHASES - 1)) ? 3'd0 : ph_r.q50 + 3'd1;
      end else begin
        ph_nxt.c50 = ph_r.c50 + 6'd1;
      end
      if (ph_r.c2000 == 11'(lpts_pkg::SPARSE_MS - 1)) begin
        ph_nxt.c2000 = '0;
        ph_nxt.h2000 = ~ph_r.h2000;
      end else begin
        ph_nxt.c2000 = ph_r.c2000 + 11'd1;
      end
      // breathe phase: bp advances by 256/P per ms, br carries the remainder
      if (ph_r.bm == W'(P - 1)) begin
        ph_nxt.bm = '0;
        ph_nxt.br = '0;
        ph_nxt.bp = '0;
      end else begin
        ph_nxt.bm = ph_r.bm + W'(1);
        if (bsum >= (W+1)'(P)) begin
          ph_nxt.br = W'(bsum - (W+1)'(P));
          ph_nxt.bp = ph_r.bp + 8'd1;
        end else begin
          ph_nxt.br = W'(bsum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      ph_r   <= '0;
    end else if (tick_en) begin
      time_r <= time_nxt;
      ph_r   <= ph_nxt;
    end
  end

endmodule

// File: rtl/lpts_pattern.sv
// LED level for one pattern code at the current millisecond phase.
module lpts_pattern (
  input  logic [2:0]       pattern,
  input  lpts_pkg::phase_t ph,
  output logic [7:0]       level
);

  logic [6:0] bq;
  logic [7:0] h;

  always_comb begin
    bq = ph.bp[6:0];
    if (bq > 7'd64) begin
      bq = 7'(8'd128 - {1'b0, bq});
    end
    h = lpts_pkg::SINE_ROM[bq];
  end

  always_comb begin
    case (pattern)
      lpts_pkg::PAT_OFF:     level = 8'd0;
      lpts_pkg::PAT_ON:      level = 8'd255;
      lpts_pkg::PAT_BREATHE: level = ph.bp[7] ? 8'((9'd255 - {1'b0, h}) >> 1)
                                              : 8'((9'd255 + {1'b0, h}) >> 1);
      lpts_pkg::PAT_FAST:    level = ph.q100[0] ? 8'd255 : 8'd0;
      lpts_pkg::PAT_SLOW:    level = ph.h500 ? 8'd255 : 8'd0;
      lpts_pkg::PAT_DOUBLE:  level = ph.q100[0] ? 8'd0 : 8'd255;
      lpts_pkg::PAT_SPARSE:  level = ph.h2000 ? 8'd255 : 8'd0;
      lpts_pkg::PAT_STUTTER: level = (ph.q50 < 3'(lpts_pkg::STUTTER_ON)) ? 8'd255 : 8'd0;
      default:               level = 8'd0;
    endcase
  end

endmodule

// File: rtl/lpts_ctrl.sv
// Pattern, level, tone and sequence state; computes the result of one item.
module lpts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  lpts_pkg::item_t  item,
  input  lpts_pkg::cfg_t   cfg,
  input  lpts_pkg::phase_t ph,
  output lpts_pkg::result_t res
);

  logic [2:0]  pat_r       [3];
  logic [2:0]  pat_nxt     [3];
  logic [7:0]  lvl_r       [3];
  logic [7:0]  lvl_nxt     [3];
  logic [7:0]  lvl_new     [3];
  logic        active_r,   active_nxt;
  logic [15:0] freq_r,     freq_nxt;
  logic [15:0] len_r,      len_nxt;
  logic [31:0] tone_el_r,  tone_el_nxt;
  logic [31:0] ref_el_r,   ref_el_nxt;
  logic [2:0]  seq_r,      seq_nxt;
  logic [2:0]  step_r,     step_nxt;

  logic [31:0] tone_inc;
  logic [31:0] ref_inc;
  logic [16:0] due;
  logic [3:0]  step_next;
  logic        do_seq;
  logic [2:0]  seq_code;

  for (genvar g = 0; g < 3; g++) begin : g_led
    lpts_pattern u_pattern (
      .pattern (pat_r[g]),
      .ph      (ph),
      .level   (lvl_new[g])
    );
  end

  always_comb begin
    pat_nxt     = pat_r;
    lvl_nxt     = lvl_r;
    active_nxt  = active_r;
    freq_nxt    = freq_r;
    len_nxt     = len_r;
    tone_el_nxt = tone_el_r;
    ref_el_nxt  = ref_el_r;
    seq_nxt     = seq_r;
    step_nxt    = step_r;
    tone_inc    = tone_el_r + 32'd1;
    ref_inc     = ref_el_r + 32'd1;
    due         = 17'(len_r) + 17'(cfg.tone_gap_ms);
    step_next   = {1'b0, step_r} + 4'd1;
    do_seq      = 1'b0;
    seq_code    = lpts_pkg::SEQ_NONE;

    if (en) begin
      case (item.kind)
        lpts_pkg::KIND_TICK: begin
          tone_el_nxt = tone_inc;
          ref_el_nxt  = ref_inc;
          if (seq_r >= lpts_pkg::SEQ_BOOT && seq_r <= lpts_pkg::SEQ_BATT) begin
            if (tone_inc >= 32'(due)) begin
              if (step_next < lpts_pkg::seq_count(seq_r) &&
                  step_next < 4'(lpts_pkg::SEQ_COLS)) begin
                step_nxt    = step_next[2:0];
                freq_nxt    = lpts_pkg::seq_freq(seq_r, step_next[1:0]);
                len_nxt     = lpts_pkg::seq_dur(seq_r, step_next[1:0]);
                tone_el_nxt = '0;
                active_nxt  = 1'b1;
              end else begin
                seq_nxt  = lpts_pkg::SEQ_NONE;
                step_nxt = '0;
              end
            end
          end else begin
            seq_nxt = lpts_pkg::SEQ_NONE;
          end
          // refresh sees the tone state left by the sequence step
          if (ref_inc >= 32'(cfg.refresh_interval_ms)) begin
            ref_el_nxt = '0;
            lvl_nxt    = lvl_new;
            if (active_nxt && tone_el_nxt >= 32'(len_nxt)) begin
              active_nxt = 1'b0;
            end
          end
        end
        lpts_pkg::KIND_EVENT: begin
          unique case (item.event_code) inside
            lpts_pkg::EVT_BOOT: begin
              pat_nxt  = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_OFF, lpts_pkg::PAT_OFF};
              do_seq   = 1'b1;
              seq_code = lpts_pkg::SEQ_BOOT;
            end
            lpts_pkg::EVT_READY:
              pat_nxt = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_DOUBLE, lpts_pkg::PAT_OFF};
            lpts_pkg::EVT_TX, lpts_pkg::EVT_RX:
              pat_nxt = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_FAST, lpts_pkg::PAT_OFF};
            lpts_pkg::EVT_SWITCH: begin
              pat_nxt  = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_OFF, lpts_pkg::PAT_FAST};
              do_seq   = 1'b1;
              seq_code = lpts_pkg::SEQ_SWITCH;
            end
            lpts_pkg::EVT_LORA_EMG:
              pat_nxt = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_SPARSE, lpts_pkg::PAT_OFF};
            lpts_pkg::EVT_ALIGN:
              pat_nxt = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_SLOW, lpts_pkg::PAT_OFF};
            lpts_pkg::EVT_EMG_RX: begin
              pat_nxt  = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_FAST, lpts_pkg::PAT_FAST};
              do_seq   = 1'b1;
              seq_code = lpts_pkg::SEQ_EMERG;
            end
            lpts_pkg::EVT_BATT_LOW: begin
              pat_nxt  = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_OFF, lpts_pkg::PAT_SLOW};
              do_seq   = 1'b1;
              seq_code = lpts_pkg::SEQ_BATT;
            end
            lpts_pkg::EVT_BATT_CRIT: begin
              pat_nxt  = '{lpts_pkg::PAT_FAST, lpts_pkg::PAT_OFF, lpts_pkg::PAT_FAST};
              do_seq   = 1'b1;
              seq_code = lpts_pkg::SEQ_BATT;
            end
            lpts_pkg::EVT_CRC_ERR:
              pat_nxt = '{lpts_pkg::PAT_BREATHE, lpts_pkg::PAT_OFF, lpts_pkg::PAT_STUTTER};
            default: ;
          endcase
        end
        lpts_pkg::KIND_LINK: begin
          case (item.link_code)
            lpts_pkg::LINK_WIFI: pat_nxt[1] = lpts_pkg::PAT_DOUBLE;
            lpts_pkg::LINK_FSO:  pat_nxt[1] = lpts_pkg::PAT_SLOW;
            lpts_pkg::LINK_LORA: pat_nxt[1] = lpts_pkg::PAT_SPARSE;
            default:             pat_nxt[1] = lpts_pkg::PAT_OFF;
          endcase
        end
        lpts_pkg::KIND_EMERG: begin
          if (item.emergency_on) begin
            pat_nxt[2] = lpts_pkg::PAT_FAST;
            do_seq     = 1'b1;
            seq_code   = lpts_pkg::SEQ_EMERG;
          end else begin
            pat_nxt[2] = lpts_pkg::PAT_OFF;
            active_nxt = 1'b0;
            seq_nxt    = lpts_pkg::SEQ_NONE;
            step_nxt   = '0;
          end
        end
        lpts_pkg::KIND_ALIGN: begin
          active_nxt = 1'b0;
          seq_nxt    = lpts_pkg::SEQ_NONE;
          step_nxt   = '0;
          if (item.tone_freq != 16'd0) begin
            freq_nxt    = item.tone_freq;
            len_nxt     = 16'(cfg.alignment_tone_ms);
            tone_el_nxt = '0;
            active_nxt  = 1'b1;
          end
        end
        lpts_pkg::KIND_SILENCE: begin
          active_nxt = 1'b0;
          seq_nxt    = lpts_pkg::SEQ_NONE;
          step_nxt   = '0;
        end
        default: ;
      endcase

      // sequence start replaces any running tone
      if (do_seq) begin
        seq_nxt     = seq_code;
        step_nxt    = '0;
        freq_nxt    = lpts_pkg::seq_freq(seq_code, 2'd0);
        len_nxt     = lpts_pkg::seq_dur(seq_code, 2'd0);
        tone_el_nxt = '0;
        active_nxt  = 1'b1;
      end
    end
  end

  always_comb begin
    res.green_level = lvl_nxt[0];
    res.blue_level  = lvl_nxt[1];
    res.red_level   = lvl_nxt[2];
    res.buzzer_on   = active_nxt;
    res.buzzer_freq = active_nxt ? freq_nxt : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r     <= '{lpts_pkg::PAT_OFF, lpts_pkg::PAT_OFF, lpts_pkg::PAT_OFF};
      lvl_r     <= '{8'd0, 8'd0, 8'd0};
      active_r  <= 1'b0;
      freq_r    <= '0;
      len_r     <= '0;
      tone_el_r <= '0;
      ref_el_r  <= '0;
      seq_r     <= lpts_pkg::SEQ_NONE;
      step_r    <= '0;
    end else begin
      pat_r     <= pat_nxt;
      lvl_r     <= lvl_nxt;
      active_r  <= active_nxt;
      freq_r    <= freq_nxt;
      len_r     <= len_nxt;
      tone_el_r <= tone_el_nxt;
      ref_el_r  <= ref_el_nxt;
      seq_r     <= seq_nxt;
      step_r    <= step_nxt;
    end
  end

endmodule

// File: rtl/led_pattern_and_tone_sequencer_unit.sv
// Top level of the LED pattern and tone sequencer: channels, config registers, pipeline.
//
//  channel | dir     | handshake              | payload
//  --------+---------+------------------------+------------------------------------------
//  in_     | slave   | in_tvalid / in_tready  | tuser kind; tdata event, link, emerg, freq
//  out_    | master  | out_tvalid / out_tready| tdata levels g/b/r, buzzer_on, buzzer_freq
//  cfg_    | APB     | psel/penable, pready=1 | refresh, alignment tone, tone gap registers
//
//  One item per cycle sustained while out_tready is high. An accepted item is held in
//  the input register, then a single combinational pass updates all state and loads
//  the result register, which drives out_tvalid. Blink and breathe phases are kept as
//  running counters, so no divider is used. rst_n is synchronous; reset clears control
//  state and loads the register defaults, but not the input and result data registers.
//  A stalled output holds both stages; in_tready drops only when both are full and stalled.
`include "assert_macros.svh"

module led_pattern_and_tone_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] event_code, [5:4] link_code, [6] emergency_on,
                                  // [22:7] tone_freq, [23] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] green_level, [15:8] blue_level, [23:16] red_level,
                                  // [24] buzzer_on, [40:25] buzzer_freq, [47:41] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  lpts_pkg::cfg_t    cfg_r;
  lpts_pkg::item_t   in_item_r;
  logic              in_vld_r;
  lpts_pkg::result_t out_data_r;
  logic              out_vld_r;
  lpts_pkg::result_t res;
  lpts_pkg::phase_t  ph_nxt;
  logic              go;
  logic              in_acc;
  logic              cfg_wr;
  logic              tick_en;

  // --- configuration port ---
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refresh_interval_ms <= 8'd20;
      cfg_r.alignment_tone_ms   <= 10'd50;
      cfg_r.tone_gap_ms         <= 10'd50;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        lpts_pkg::REG_REFRESH: cfg_r.refresh_interval_ms <= cfg_pwdata[7:0];
        lpts_pkg::REG_ALIGN:   cfg_r.alignment_tone_ms   <= cfg_pwdata[9:0];
        lpts_pkg::REG_GAP:     cfg_r.tone_gap_ms         <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      lpts_pkg::REG_REFRESH: cfg_prdata = 32'(cfg_r.refresh_interval_ms);
      lpts_pkg::REG_ALIGN:   cfg_prdata = 32'(cfg_r.alignment_tone_ms);
      lpts_pkg::REG_GAP:     cfg_prdata = 32'(cfg_r.tone_gap_ms);
      default:               cfg_prdata = '0;
    endcase
  end

  // --- pipeline handshake ---
  // go: input register holds an item and the result register can take its result
  assign go        = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | go;
  assign in_acc    = in_tvalid & in_tready;
  assign tick_en   = go & (in_item_r.kind == lpts_pkg::KIND_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.kind         <= in_tuser;
      in_item_r.event_code   <= in_tdata[3:0];
      in_item_r.link_code    <= in_tdata[5:4];
      in_item_r.emergency_on <= in_tdata[6];
      in_item_r.tone_freq    <= in_tdata[22:7];
    end
  end

  // --- processing ---
  lpts_timebase u_timebase (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (tick_en),
    .ph_nxt  (ph_nxt)
  );

  lpts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (go),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .ph    (ph_nxt),
    .res   (res)
  );

  // --- result register ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_data_r.buzzer_freq, out_data_r.buzzer_on,
                       out_data_r.red_level, out_data_r.blue_level, out_data_r.green_level};

  // --- assertions ---
  `ASSERT_NEXT(a_go_fills_out, go, out_vld_r, "processed item did not reach result register")
  `ASSERT_NEXT(a_in_stage_hold, in_vld_r && !go, in_vld_r && $stable(in_item_r),
               "stalled input stage lost its item")
  `ASSERT_NOW(a_buzzer_quiet, out_vld_r && !out_data_r.buzzer_on,
              out_data_r.buzzer_freq == 16'd0, "silent buzzer shows a frequency")

endmodule

// File: tb/tb.sv
// Self-checking testbench for the LED pattern and tone sequencer unit.
module tb;
  import lpts_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [3:0] event_code, [5:4] link_code, [6] emergency_on,
                           // [22:7] tone_freq, [23] zero
  logic [2:0]  in_tuser;   // [2:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [7:0] green, [15:8] blue, [23:16] red, [24] buzzer_on,
                           // [40:25] buzzer_freq, [47:41] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  led_pattern_and_tone_sequencer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Constant tables of the sequencer
  // ---------------------------------------------------------------------------
  localparam logic [7:0] SINE_Q [0:64] = '{
    8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
    8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
    8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
    8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
    8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
    8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
    8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255,
    8'd255
  };

  // row = sequence code, column = tone number
  localparam logic [15:0] TONE_HZ [0:4][0:2] = '{
    '{16'd0, 16'd0, 16'd0}, '{16'd523, 16'd659, 16'd784}, '{16'd600, 16'd500, 16'd400},
    '{16'd1047, 16'd1047, 16'd0}, '{16'd200, 16'd200, 16'd0}
  };
  localparam logic [15:0] TONE_MS [0:4][0:2] = '{
    '{16'd0, 16'd0, 16'd0}, '{16'd150, 16'd150, 16'd300}, '{16'd100, 16'd100, 16'd200},
    '{16'd100, 16'd100, 16'd0}, '{16'd200, 16'd400, 16'd0}
  };
  localparam int unsigned TONES_IN_SEQ [0:4] = '{0, 3, 3, 2, 2};

  // ---------------------------------------------------------------------------
  // Shadow state of the sequencer
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_refresh;
  logic [9:0]  cfg_align;
  logic [9:0]  cfg_gap;

  logic [31:0] clock_ms;
  logic [31:0] refreshed_at_ms;
  logic [2:0]  pattern_of [0:2];   // green, blue, red
  logic [7:0]  level_of [0:2];
  logic        buzzing;
  logic [15:0] buzz_hz;
  logic [31:0] tone_began_ms;
  logic [15:0] tone_len_ms;
  logic [2:0]  seq_id;
  logic [2:0]  seq_pos;

  result_t     due_outputs [$];
  int          errors;

  // drive knobs shared between the stimulus and the result sink
  bit          send_idle;
  bit          recv_idle;
  bit          hold_pending;

  function automatic logic [7:0] level_for(logic [2:0] pat, logic [31:0] t_ms);
    int unsigned t, p, q, ph;
    t = t_ms;
    case (pat)
      PAT_ON: return 8'd255;
      PAT_BREATHE: begin
        p = ((t % BREATHE_PERIOD_MS) * 256) / BREATHE_PERIOD_MS;
        q = p & 127;
        if (q > 64) q = 128 - q;
        return 8'((p < 128 ? 255 + SINE_Q[q] : 255 - SINE_Q[q]) >> 1);
      end
      PAT_FAST:   return ((t / 100) & 1) ? 8'd255 : 8'd0;
      PAT_SLOW:   return ((t / 500) & 1) ? 8'd255 : 8'd0;
      PAT_DOUBLE: begin
        ph = (t / 100) % 4;
        return (ph == 0 || ph == 2) ? 8'd255 : 8'd0;
      end
      PAT_SPARSE: return ((t / 2000) & 1) ? 8'd255 : 8'd0;
      PAT_STUTTER: begin
        ph = (t / 50) % 6;
        return (ph < 3) ? 8'd255 : 8'd0;
      end
      default: return 8'd0;
    endcase
  endfunction

  task automatic start_tone(input logic [15:0] hz, input logic [15:0] len);
    buzz_hz       = hz;
    tone_len_ms   = len;
    tone_began_ms = clock_ms;
    buzzing       = 1'b1;
  endtask

  task automatic silence_all();
    buzzing = 1'b0;
    seq_id  = SEQ_NONE;
    seq_pos = '0;
  endtask

  task automatic begin_sequence(input logic [2:0] s);
    seq_id  = s;
    seq_pos = '0;
    start_tone(TONE_HZ[s][0], TONE_MS[s][0]);
  endtask

  task automatic set_patterns(input logic [2:0] g, input logic [2:0] b, input logic [2:0] r);
    pattern_of[0] = g;
    pattern_of[1] = b;
    pattern_of[2] = r;
  endtask

  // Applies one item to the shadow state and yields the output it produces.
  task automatic predict_outputs(input item_t it, output result_t res);
    logic [31:0] due;
    int unsigned nxt, cnt;
    case (it.kind)
      KIND_TICK: begin
        clock_ms = clock_ms + 1;
        if (seq_id >= SEQ_BOOT && seq_id <= SEQ_BATT) begin
          due = 32'(tone_len_ms) + 32'(cfg_gap);
          if (clock_ms - tone_began_ms >= due) begin
            nxt = seq_pos + 1;
            cnt = TONES_IN_SEQ[seq_id] > MAX_TONES ? MAX_TONES : TONES_IN_SEQ[seq_id];
            if (nxt < cnt && nxt < 3) begin
              seq_pos = 3'(nxt);
              start_tone(TONE_HZ[seq_id][nxt], TONE_MS[seq_id][nxt]);
            end else begin
              seq_id  = SEQ_NONE;
              seq_pos = '0;
            end
          end
        end else begin
          seq_id = SEQ_NONE;
        end
        if (clock_ms - refreshed_at_ms >= 32'(cfg_refresh)) begin
          refreshed_at_ms = clock_ms;
          for (int i = 0; i < 3; i++) level_of[i] = level_for(pattern_of[i], clock_ms);
          if (buzzing && clock_ms - tone_began_ms >= 32'(tone_len_ms)) buzzing = 1'b0;
        end
      end
      KIND_EVENT: begin
        case (it.event_code)
          EVT_BOOT: begin
            set_patterns(PAT_BREATHE, PAT_OFF, PAT_OFF);
            begin_sequence(SEQ_BOOT);
          end
          EVT_READY:           set_patterns(PAT_BREATHE, PAT_DOUBLE, PAT_OFF);
          EVT_TX, EVT_RX:      set_patterns(PAT_BREATHE, PAT_FAST, PAT_OFF);
          EVT_SWITCH: begin
            set_patterns(PAT_BREATHE, PAT_OFF, PAT_FAST);
            begin_sequence(SEQ_SWITCH);
          end
          EVT_LORA_EMG:        set_patterns(PAT_BREATHE, PAT_SPARSE, PAT_OFF);
          EVT_ALIGN:           set_patterns(PAT_BREATHE, PAT_SLOW, PAT_OFF);
          EVT_EMG_RX: begin
            set_patterns(PAT_BREATHE, PAT_FAST, PAT_FAST);
            begin_sequence(SEQ_EMERG);
          end
          EVT_BATT_LOW: begin
            set_patterns(PAT_BREATHE, PAT_OFF, PAT_SLOW);
            begin_sequence(SEQ_BATT);
          end
          EVT_BATT_CRIT: begin
            set_patterns(PAT_FAST, PAT_OFF, PAT_FAST);
            begin_sequence(SEQ_BATT);
          end
          EVT_CRC_ERR:         set_patterns(PAT_BREATHE, PAT_OFF, PAT_STUTTER);
          default: ;
        endcase
      end
      KIND_LINK: begin
        case (it.link_code)
          LINK_WIFI: pattern_of[1] = PAT_DOUBLE;
          LINK_FSO:  pattern_of[1] = PAT_SLOW;
          LINK_LORA: pattern_of[1] = PAT_SPARSE;
          default:   pattern_of[1] = PAT_OFF;
        endcase
      end
      KIND_EMERG: begin
        if (it.emergency_on) begin
          pattern_of[2] = PAT_FAST;
          begin_sequence(SEQ_EMERG);
        end else begin
          pattern_of[2] = PAT_OFF;
          silence_all();
        end
      end
      KIND_ALIGN: begin
        silence_all();
        if (it.tone_freq != 16'd0) start_tone(it.tone_freq, 16'(cfg_align));
      end
      KIND_SILENCE: silence_all();
      default: ;   // unknown kinds leave everything alone
    endcase
    res.green_level = level_of[0];
    res.blue_level  = level_of[1];
    res.red_level   = level_of[2];
    res.buzzer_on   = buzzing;
    res.buzzer_freq = buzzing ? buzz_hz : 16'd0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t make_command();
    item_t it;
    int unsigned k, f;
    k = $urandom_range(0, 99);
    if (k < 45)      it.kind = KIND_EVENT;
    else if (k < 60) it.kind = KIND_LINK;
    else if (k < 72) it.kind = KIND_EMERG;
    else if (k < 84) it.kind = KIND_ALIGN;
    else if (k < 90) it.kind = KIND_SILENCE;
    else if (k < 95) it.kind = 3'($urandom_range(6, 7));
    else             it.kind = KIND_TICK;
    it.event_code   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 11));
    it.link_code    = 2'($urandom);
    it.emergency_on = 1'($urandom);
    f = $urandom_range(0, 99);
    it.tone_freq    = (f < 10) ? 16'd0 : (f < 15) ? 16'hFFFF : 16'($urandom);
    return it;
  endfunction

  // Offers one item, waits for it to be taken, and records what must come back.
  task automatic drive_item(input item_t it, input bit typed, input result_t typed_out);
    int      gap;
    result_t predicted;
    @(negedge clk);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {1'b0, it.tone_freq, it.emergency_on, it.link_code, it.event_code};
    do @(posedge clk); while (!in_tready);
    predict_outputs(it, predicted);
    due_outputs.push_back(typed ? typed_out : predicted);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] readback;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_REFRESH: cfg_refresh = val[7:0];
      REG_ALIGN:   cfg_align   = val[9:0];
      REG_GAP:     cfg_gap     = val[9:0];
      default: ;
    endcase
    // read it back
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== val) begin
      $display("%0t: register %0d readback expected %0d actual %0d", $time, idx, val,
               readback);
      errors++;
    end
  endtask

  task automatic drain_results();
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed items: extremes, every kind and event, ignored codes
  // ---------------------------------------------------------------------------
  typedef struct packed {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  localparam int N_ROWS = 27;
  localparam row_t DIRECTED [0:N_ROWS-1] = '{
    '{'{KIND_TICK,    4'd15,         2'd3,      1'b1, 16'hFFFF}, 1'b1, '0},
    '{'{3'd6,         4'd15,         2'd3,      1'b1, 16'hFFFF}, 1'b1, '0},
    '{'{3'd7,         4'd0,          2'd0,      1'b0, 16'h0000}, 1'b1, '0},
    '{'{KIND_EVENT,   4'd0,          2'd0,      1'b0, 16'h0000}, 1'b1, '0},
    '{'{KIND_EVENT,   4'd12,         2'd0,      1'b0, 16'h0000}, 1'b1, '0},
    '{'{KIND_EVENT,   4'd15,         2'd3,      1'b1, 16'hFFFF}, 1'b1, '0},
    '{'{KIND_EVENT,   EVT_BOOT,      2'd0,      1'b0, 16'h0000}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b1, 16'd523}},
    '{'{KIND_LINK,    4'd0,          2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_LINK,    4'd0,          LINK_WIFI, 1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_LINK,    4'd0,          LINK_FSO,  1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_LINK,    4'd15,         LINK_LORA, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{KIND_EVENT,   EVT_READY,     2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_TICK,    4'd0,          2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_EVENT,   EVT_SWITCH,    2'd0,      1'b0, 16'h0000}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b1, 16'd600}},
    '{'{KIND_EMERG,   4'd0,          2'd0,      1'b1, 16'h0000}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b1, 16'd1047}},
    '{'{KIND_EMERG,   4'd15,         2'd3,      1'b0, 16'hFFFF}, 1'b1, '0},
    '{'{KIND_ALIGN,   4'd0,          2'd0,      1'b0, 16'hFFFF}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b1, 16'hFFFF}},
    '{'{KIND_ALIGN,   4'd15,         2'd3,      1'b1, 16'h0000}, 1'b1, '0},
    '{'{KIND_EVENT,   EVT_BATT_LOW,  2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_SILENCE, 4'd15,         2'd3,      1'b1, 16'hFFFF}, 1'b1, '0},
    '{'{KIND_EVENT,   EVT_TX,        2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_EVENT,   EVT_RX,        2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_EVENT,   EVT_LORA_EMG,  2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_EVENT,   EVT_ALIGN,     2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_EVENT,   EVT_EMG_RX,    2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_EVENT,   EVT_BATT_CRIT, 2'd0,      1'b0, 16'h0000}, 1'b0, '0},
    '{'{KIND_EVENT,   EVT_CRC_ERR,   2'd0,      1'b0, 16'h0000}, 1'b0, '0}
  };

  localparam int N_PHASES   = 5;
  localparam int PHASE_ITEMS = 380;

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    item_t       it;
    int unsigned run_left, r, sent;
    logic [31:0] refresh_val, align_val, gap_val;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    errors      = 0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    hold_pending = 1'b0;

    cfg_refresh     = 8'd20;
    cfg_align       = 10'd50;
    cfg_gap         = 10'd50;
    clock_ms        = '0;
    refreshed_at_ms = '0;
    set_patterns(PAT_OFF, PAT_OFF, PAT_OFF);
    for (int i = 0; i < 3; i++) level_of[i] = '0;
    buzzing       = 1'b0;
    buzz_hz       = '0;
    tone_began_ms = '0;
    tone_len_ms   = '0;
    seq_id        = SEQ_NONE;
    seq_pos       = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++)
      drive_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);
    @(negedge clk);
    in_tvalid <= 1'b0;
    drain_results();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin refresh_val = 20;  align_val = 50;   gap_val = 50;   end
        1: begin refresh_val = 0;   align_val = 0;    gap_val = 0;    end
        2: begin refresh_val = 255; align_val = 1023; gap_val = 1023; end
        3: begin refresh_val = 1;   align_val = $urandom_range(1, 1023); gap_val = 0; end
        default: begin
          refresh_val = $urandom_range(0, 255);
          align_val   = $urandom_range(0, 1023);
          gap_val     = $urandom_range(0, 1023);
        end
      endcase
      write_register(REG_REFRESH, refresh_val);
      write_register(REG_ALIGN, align_val);
      write_register(REG_GAP, gap_val);

      // last phase runs at full rate on both sides
      send_idle = (ph != N_PHASES - 1);
      recv_idle = (ph != N_PHASES - 1);
      run_left  = 0;
      sent      = 0;
      while (sent < PHASE_ITEMS) begin
        if (run_left > 0) begin
          // long tick runs let tones and sequences play out, with rare commands mixed in
          if ($urandom_range(0, 29) == 0) begin
            it = make_command();
          end else begin
            it              = make_command();
            it.kind         = KIND_TICK;
          end
          run_left--;
        end else begin
          it = make_command();
          r  = $urandom_range(0, 99);
          run_left = (r < 60) ? $urandom_range(0, 20) :
                     (r < 85) ? $urandom_range(20, 150) : $urandom_range(150, 700);
        end
        drive_item(it, 1'b0, '0);
        sent++;
        if (ph == 1 && sent == 150) begin
          // receiver stalls for a long stretch while items keep coming
          hold_pending = 1'b1;
          send_idle    = 1'b0;
        end
        if (ph != N_PHASES - 1 && sent % 64 == 0) begin
          send_idle = ($urandom_range(0, 2) != 0);
          recv_idle = ($urandom_range(0, 2) != 0);
        end
      end
      @(negedge clk);
      in_tvalid <= 1'b0;
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && due_outputs.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold counted here
  // ---------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (80) @(negedge clk);
        out_tready <= 1'b1;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  result_t oldest;
  result_t seen;

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.green_level = out_tdata[7:0];
      seen.blue_level  = out_tdata[15:8];
      seen.red_level   = out_tdata[23:16];
      seen.buzzer_on   = out_tdata[24];
      seen.buzzer_freq = out_tdata[40:25];
      if (due_outputs.size() == 0) begin
        $display("%0t: unexpected item expected none actual %h", $time, out_tdata);
        errors++;
      end else begin
        oldest = due_outputs.pop_front();
        report_field("green_level", 16'(oldest.green_level), 16'(seen.green_level));
        report_field("blue_level",  16'(oldest.blue_level),  16'(seen.blue_level));
        report_field("red_level",   16'(oldest.red_level),   16'(seen.red_level));
        report_field("buzzer_on",   16'(oldest.buzzer_on),   16'(seen.buzzer_on));
        report_field("buzzer_freq", oldest.buzzer_freq,      seen.buzzer_freq);
      end
    end
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule
